### rtl/h264sfn_pkg.sv
// Shared types and constants for the slice frame-number checker.
// No dependencies; used by h264_slice_frame_num_checker_top.
`timescale 1ns / 1ps

package h264sfn_pkg;

    localparam int FRAME_NUM_MAX_BITS = 16;
    localparam int FRAME_NUM_MIN_BITS = 4;
    localparam int ZERO_RUN_LIMIT     = 32;

    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [4:0] TYPE_MASK  = 5'h1F;

    localparam logic [4:0] NAL_SLICE     = 5'd1;
    localparam logic [4:0] NAL_SLICE_IDR = 5'd5;
    localparam logic [4:0] NAL_SEI       = 5'd6;
    localparam logic [4:0] NAL_SPS       = 5'd7;
    localparam logic [4:0] NAL_PPS       = 5'd8;

    // configuration register indexes
    localparam logic CFG_FRAME_NUM_BITS = 1'b0;
    localparam logic CFG_MAX_FRAME_GAP  = 1'b1;

    localparam logic [4:0] FRAME_NUM_BITS_RST = 5'd4;
    localparam logic [7:0] MAX_FRAME_GAP_RST  = 8'd5;

    // field index of the frame number among the slice header fields
    localparam logic [1:0] FIELD_FRAME_NUM = 2'd3;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_TYPE4   = 3'd1,
        PH_TYPE3   = 3'd2,
        PH_CONFIRM = 3'd3,
        PH_SLICE   = 3'd4,
        PH_DONE    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        OUT_SLICE_OK = 3'd0,
        OUT_MARKER   = 3'd1,
        OUT_NO_START = 3'd2,
        OUT_OTHER    = 3'd3,
        OUT_GAP      = 3'd4
    } outcome_t;

    function automatic logic is_slice(input logic [4:0] t);
        return (t == NAL_SLICE) || (t == NAL_SLICE_IDR);
    endfunction

endpackage

### rtl/h264_slice_frame_num_checker_top.sv
// Slice frame-number checker: Annex-B start code search, NAL type and slice
// header frame number parse, modular gap check. Uses h264sfn_pkg.
// The final byte passes the input register, then its verdict is registered onto m_tvalid.
// Throughput: one byte per cycle, all eight exp-Golomb bit steps in one pass; a
// final byte waits only while the previous verdict is held by m_tready low.
// Reset (aresetn low, synchronous): parser, history, flags clear; registers to 4, 5.
`timescale 1ns / 1ps

module h264_slice_frame_num_checker_top (
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        s_tuser,   // [0] forget_history
    // verdicts
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] fragment_valid, [3:1] outcome,
                                   // [8:4] nal_type, [24:9] frame_number, rest 0
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       in_forget_reg;

    // configuration
    logic [4:0] frame_num_bits_reg;
    logic [7:0] max_frame_gap_reg;

    // parser state
    h264sfn_pkg::phase_t phase_reg, phase_next;
    logic [23:0] window_reg, window_next;
    logic [2:0]  bytes_reg, bytes_next;
    logic [1:0]  field_reg, field_next;
    logic [5:0]  zero_run_reg, zero_run_next;
    logic [5:0]  suffix_reg, suffix_next;
    logic [15:0] accum_reg, accum_next;
    logic [4:0]  type_reg, type_next;
    logic        hist_valid_reg, hist_valid_next;
    logic [15:0] last_frame_reg, last_frame_next;

    // result register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic        advance;
    logic        out_load;
    logic        run_bits;
    logic        cur_bit;
    logic [4:0]  width;
    logic [15:0] mask;
    logic [4:0]  remain;
    logic [15:0] fnum;
    logic [15:0] gap;
    logic        hist_eff;
    logic [15:0] last_eff;
    logic        res_valid;
    h264sfn_pkg::outcome_t res_outcome;
    logic [4:0]  res_type;
    logic [15:0] res_frame;

    // only a final byte needs room in the result register
    assign advance   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign out_load  = advance && in_last_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    // frame number width saturated into its legal range
    always_comb begin
        if (frame_num_bits_reg < 5'(h264sfn_pkg::FRAME_NUM_MIN_BITS)) begin
            width = 5'(h264sfn_pkg::FRAME_NUM_MIN_BITS);
        end else if (frame_num_bits_reg > 5'(h264sfn_pkg::FRAME_NUM_MAX_BITS)) begin
            width = 5'(h264sfn_pkg::FRAME_NUM_MAX_BITS);
        end else begin
            width = frame_num_bits_reg;
        end
        mask = 16'((17'd1 << width) - 17'd1);
    end

    // start code search, NAL type and slice header bit walk for one byte
    always_comb begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        field_next    = field_reg;
        zero_run_next = zero_run_reg;
        suffix_next   = suffix_reg;
        accum_next    = accum_reg;
        window_next   = {window_reg[15:0], in_byte_reg};
        bytes_next    = (bytes_reg == 3'd7) ? bytes_reg : bytes_reg + 3'd1;
        run_bits      = 1'b0;
        cur_bit       = 1'b0;

        unique case (phase_reg)
            h264sfn_pkg::PH_SEARCH: begin
                if (in_byte_reg == h264sfn_pkg::START_BYTE && bytes_reg >= 3'd2 &&
                    window_reg[15:0] == 16'd0) begin
                    if (bytes_reg >= 3'd3 && window_reg[23:16] == 8'd0) begin
                        phase_next = h264sfn_pkg::PH_TYPE4;
                    end else begin
                        phase_next = h264sfn_pkg::PH_TYPE3;
                    end
                end
            end
            h264sfn_pkg::PH_TYPE4: begin
                type_next  = in_byte_reg[4:0] & h264sfn_pkg::TYPE_MASK;
                phase_next = h264sfn_pkg::is_slice(type_next) ?
                             h264sfn_pkg::PH_SLICE : h264sfn_pkg::PH_DONE;
            end
            h264sfn_pkg::PH_TYPE3: begin
                type_next  = in_byte_reg[4:0] & h264sfn_pkg::TYPE_MASK;
                phase_next = h264sfn_pkg::PH_CONFIRM;
            end
            h264sfn_pkg::PH_CONFIRM: begin
                // a 3-byte code only counts once the byte after the header shows up
                if (h264sfn_pkg::is_slice(type_reg)) begin
                    phase_next = h264sfn_pkg::PH_SLICE;
                    run_bits   = 1'b1;
                end else begin
                    phase_next = h264sfn_pkg::PH_DONE;
                end
            end
            h264sfn_pkg::PH_SLICE: begin
                run_bits = 1'b1;
            end
            h264sfn_pkg::PH_DONE: begin
            end
            default: begin
                phase_next = h264sfn_pkg::PH_SEARCH;
            end
        endcase

        // MSB first; three ue(v) fields skipped, then the frame number
        for (int j = 0; j < 8; j++) begin
            cur_bit = in_byte_reg[3'(7 - j)];
            if (run_bits && phase_next == h264sfn_pkg::PH_SLICE) begin
                if (field_next == h264sfn_pkg::FIELD_FRAME_NUM) begin
                    accum_next = {accum_next[14:0], cur_bit};
                    if (suffix_next != 6'd0) begin
                        suffix_next = suffix_next - 6'd1;
                    end
                    if (suffix_next == 6'd0) begin
                        phase_next = h264sfn_pkg::PH_DONE;
                    end
                end else if (suffix_next != 6'd0) begin
                    suffix_next = suffix_next - 6'd1;
                    if (suffix_next == 6'd0) begin
                        field_next = field_next + 2'd1;
                        if (field_next == h264sfn_pkg::FIELD_FRAME_NUM) begin
                            suffix_next = 6'(width);
                        end
                    end
                end else if (!cur_bit &&
                             zero_run_next < 6'(h264sfn_pkg::ZERO_RUN_LIMIT)) begin
                    zero_run_next = zero_run_next + 6'd1;
                end else begin
                    // terminator (or forced one after an overlong run)
                    if (zero_run_next == 6'd0) begin
                        field_next = field_next + 2'd1;
                        if (field_next == h264sfn_pkg::FIELD_FRAME_NUM) begin
                            suffix_next = 6'(width);
                        end
                    end else begin
                        suffix_next = zero_run_next;
                    end
                    zero_run_next = 6'd0;
                end
            end
        end
    end

    // verdict for a final byte
    always_comb begin
        hist_eff = in_forget_reg ? 1'b0 : hist_valid_reg;
        last_eff = in_forget_reg ? 16'd0 : last_frame_reg;
        // bits not yet seen read as zero
        remain = (field_next == h264sfn_pkg::FIELD_FRAME_NUM) ? suffix_next[4:0] : width;
        fnum   = 16'(32'(accum_next) << remain) & mask;
        gap    = (fnum - last_eff) & mask;

        res_valid   = 1'b0;
        res_outcome = h264sfn_pkg::OUT_NO_START;
        res_type    = 5'd0;
        res_frame   = 16'd0;
        if (phase_next == h264sfn_pkg::PH_SLICE || phase_next == h264sfn_pkg::PH_DONE) begin
            res_type = type_next;
            if (h264sfn_pkg::is_slice(type_next)) begin
                res_frame = fnum;
                if (hist_eff && gap > {8'd0, max_frame_gap_reg}) begin
                    res_outcome = h264sfn_pkg::OUT_GAP;
                end else begin
                    res_outcome = h264sfn_pkg::OUT_SLICE_OK;
                    res_valid   = 1'b1;
                end
            end else if (type_next == h264sfn_pkg::NAL_SEI ||
                         type_next == h264sfn_pkg::NAL_SPS ||
                         type_next == h264sfn_pkg::NAL_PPS) begin
                res_outcome = h264sfn_pkg::OUT_MARKER;
                res_valid   = 1'b1;
            end else begin
                res_outcome = h264sfn_pkg::OUT_OTHER;
            end
        end

        hist_valid_next = hist_eff;
        last_frame_next = last_eff;
        if (in_last_reg && res_outcome == h264sfn_pkg::OUT_SLICE_OK) begin
            hist_valid_next = 1'b1;
            last_frame_next = fnum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            frame_num_bits_reg <= h264sfn_pkg::FRAME_NUM_BITS_RST;
            max_frame_gap_reg  <= h264sfn_pkg::MAX_FRAME_GAP_RST;
            phase_reg          <= h264sfn_pkg::PH_SEARCH;
            window_reg         <= '0;
            bytes_reg          <= '0;
            field_reg          <= '0;
            zero_run_reg       <= '0;
            suffix_reg         <= '0;
            accum_reg          <= '0;
            type_reg           <= '0;
            hist_valid_reg     <= 1'b0;
            last_frame_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    h264sfn_pkg::CFG_FRAME_NUM_BITS: frame_num_bits_reg <= cfg_data[4:0];
                    h264sfn_pkg::CFG_MAX_FRAME_GAP:  max_frame_gap_reg  <= cfg_data;
                    default: begin
                    end
                endcase
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                hist_valid_reg <= hist_valid_next;
                last_frame_reg <= last_frame_next;
                if (in_last_reg) begin
                    phase_reg    <= h264sfn_pkg::PH_SEARCH;
                    window_reg   <= '0;
                    bytes_reg    <= '0;
                    field_reg    <= '0;
                    zero_run_reg <= '0;
                    suffix_reg   <= '0;
                    accum_reg    <= '0;
                    type_reg     <= '0;
                end else begin
                    phase_reg    <= phase_next;
                    window_reg   <= window_next;
                    bytes_reg    <= bytes_next;
                    field_reg    <= field_next;
                    zero_run_reg <= zero_run_next;
                    suffix_reg   <= suffix_next;
                    accum_reg    <= accum_next;
                    type_reg     <= type_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg   <= s_tdata;
            in_last_reg   <= s_tlast;
            in_forget_reg <= s_tuser;
        end
        if (out_load) begin
            out_data_reg <= {7'd0, res_frame, res_type, 3'(res_outcome), res_valid};
        end
    end

    // verdict flag agrees with its outcome code
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (res_valid == (res_outcome == h264sfn_pkg::OUT_SLICE_OK ||
                                    res_outcome == h264sfn_pkg::OUT_MARKER)))
        else $error("fragment_valid disagrees with outcome");

    // no start code means no type and no frame number
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_outcome == h264sfn_pkg::OUT_NO_START) |->
            (res_type == 5'd0 && res_frame == 16'd0))
        else $error("no-start verdict carries type or frame");

    // an accepted slice is remembered for the next gap check
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && res_outcome == h264sfn_pkg::OUT_SLICE_OK) |=>
            (hist_valid_reg && last_frame_reg == $past(res_frame)))
        else $error("accepted slice not stored in history");

    // after a final byte the parser is back to searching
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (phase_reg == h264sfn_pkg::PH_SEARCH && bytes_reg == 3'd0))
        else $error("parser state not cleared after verdict");

endmodule
